/* hdl/tjp_pkg.sv */
// Shared types and codes for the trapezoidal joint profile generator.
package tjp_pkg;

  // Item opcodes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Register indexes on the config port
  localparam logic REG_ACCEL   = 1'b0;
  localparam logic REG_SEGMENT = 1'b1;

  localparam int ANGLE_W   = 32;
  localparam int TIME_W    = 32;
  localparam int ACCEL_W   = 10;
  localparam int JOINT_W   = 3;
  localparam int POS_OUTS  = 6;
  // num/den hold up to twice the widest tick count
  localparam int NUM_MAX_W = 32;

  localparam logic [ACCEL_W-1:0] ACCEL_RESET   = 10'd50;
  localparam int                 SEGMENT_RESET = 200;

  // One queued job: either a joint load or a classified tick
  typedef struct packed {
    logic                 tick;
    logic [JOINT_W-1:0]   joint;
    logic [ANGLE_W-1:0]   start_angle;
    logic [ANGLE_W-1:0]   end_angle;
    logic [NUM_MAX_W-1:0] num;
    logic [NUM_MAX_W-1:0] den;
    logic [TIME_W-1:0]    time_ticks;
    logic                 last;
  } job_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DIFF,
    BK_MUL,
    BK_RND,
    BK_DIV,
    BK_FIX,
    BK_SEND
  } back_state_e;

endpackage

/* hdl/tjp_if.sv */
// Valid/ready channel interfaces for input items and result words.
interface tjp_req_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [2:0]  joint;
  logic [31:0] start_angle;
  logic [31:0] end_angle;
  modport source (output valid, output op, output joint, output start_angle,
                  output end_angle, input ready);
  modport sink   (input valid, input op, input joint, input start_angle,
                  input end_angle, output ready);
endinterface

interface tjp_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] time_ticks;
  logic [31:0] pos_j0;
  logic [31:0] pos_j1;
  logic [31:0] pos_j2;
  logic [31:0] pos_j3;
  logic [31:0] pos_j4;
  logic [31:0] pos_j5;
  logic        segment_end;
  modport source (output valid, output time_ticks, output pos_j0, output pos_j1,
                  output pos_j2, output pos_j3, output pos_j4, output pos_j5,
                  output segment_end, input ready);
  modport sink   (input valid, input time_ticks, input pos_j0, input pos_j1,
                  input pos_j2, input pos_j3, input pos_j4, input pos_j5,
                  input segment_end, output ready);
endinterface

/* hdl/tjp_fifo.sv */
// Small register queue between the front and back parts.
module tjp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [PW:0]      cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == (PW+1)'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(DEPTH-1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(DEPTH-1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end
endmodule

/* hdl/tjp_front.sv */
// Front part: accepts items, keeps segment time and works out each tick's phase terms.
module tjp_front #(
  parameter int JOINTS     = 6,
  parameter int TICK_WIDTH = 11
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  tjp_req_if.sink                       req_i,
  input  logic [tjp_pkg::ACCEL_W-1:0]   accel_i,
  input  logic [TICK_WIDTH-1:0]         segment_i,
  input  logic                          full_i,
  output logic                          push_o,
  output tjp_pkg::job_t                 job_o
);
  localparam int TW = TICK_WIDTH;
  localparam int NW = 2 * TICK_WIDTH;
  localparam int AW = (tjp_pkg::ACCEL_W > TW) ? tjp_pkg::ACCEL_W : TW;

  logic [TW-1:0]  tick_q, tick_d;
  logic [31:0]    base_q, base_d;
  logic [TW-1:0]  seg_t, half_t, a_t, ta_t, tq, u_t;
  logic [AW-1:0]  a_w;
  logic [TW:0]    two_t_m_a;
  logic [NW:0]    lin;
  logic [NW-1:0]  num, den, sq_t, sq_u;
  logic           last, accept, joint_ok;

  assign req_i.ready = !full_i;
  assign accept      = req_i.valid && !full_i;
  assign joint_ok    = ({1'b0, req_i.joint} < 4'(JOINTS));
  assign push_o      = accept && ((req_i.op == tjp_pkg::OP_TICK) || joint_ok);

  always_comb begin
    seg_t  = (segment_i < TW'(2)) ? TW'(2) : segment_i;
    half_t = seg_t >> 1;
    a_w    = (accel_i == '0) ? AW'(1) : AW'(accel_i);
    if (a_w > AW'(half_t)) begin
      a_w = AW'(half_t);
    end
    a_t  = a_w[TW-1:0];
    ta_t = seg_t - a_t;
    tq   = (tick_q > seg_t) ? seg_t : tick_q;
    last = (tq == seg_t);
    // closed-form numerator of the distance fraction per phase
    two_t_m_a = {tq, 1'b0} - (TW+1)'(a_t);
    sq_t      = NW'(tq) * NW'(tq);
    u_t       = tq - ta_t;
    sq_u      = NW'(u_t) * NW'(u_t);
    lin       = (NW+1)'(a_t) * (NW+1)'(two_t_m_a);
    if (tq <= a_t) begin
      num = sq_t;
    end else if (tq <= ta_t) begin
      num = lin[NW-1:0];
    end else begin
      num = lin[NW-1:0] - sq_u;
    end
    den = NW'({NW'(a_t) * NW'(ta_t), 1'b0});
  end

  always_comb begin
    job_o             = '0;
    job_o.tick        = req_i.op;
    job_o.joint       = req_i.joint;
    job_o.start_angle = req_i.start_angle;
    job_o.end_angle   = req_i.end_angle;
    job_o.num         = tjp_pkg::NUM_MAX_W'(num);
    job_o.den         = tjp_pkg::NUM_MAX_W'(den);
    job_o.time_ticks  = base_q + 32'(tq);
    job_o.last        = last;
  end

  always_comb begin
    tick_d = tick_q;
    base_d = base_q;
    if (accept && (req_i.op == tjp_pkg::OP_TICK)) begin
      if (last) begin
        tick_d = '0;
        base_d = base_q + 32'(seg_t);
      end else begin
        tick_d = tq + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q <= '0;
      base_q <= '0;
    end else begin
      tick_q <= tick_d;
      base_q <= base_d;
    end
  end
endmodule

/* hdl/tjp_back.sv */
// Back part: joint stores, shared multiplier and divider, result word register.
module tjp_back #(
  parameter int JOINTS     = 6,
  parameter int POS_WIDTH  = 32,
  parameter int TICK_WIDTH = 11
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_valid_i,
  input  tjp_pkg::job_t job_i,
  output logic          job_pop_o,
  tjp_rsp_if.source     rsp_o
);
  localparam int NW    = 2 * TICK_WIDTH;
  localparam int MW    = 32;
  localparam int QB    = 32;
  localparam int RADIX = 4;
  localparam int ITER  = QB / RADIX;
  localparam int CW    = $clog2(ITER);
  localparam int XW    = MW + NW;
  localparam int JW    = (JOINTS > 1) ? $clog2(JOINTS) : 1;
  localparam int NE    = (JOINTS < tjp_pkg::POS_OUTS) ? JOINTS : tjp_pkg::POS_OUTS;
  localparam int QW    = (POS_WIDTH > 34) ? POS_WIDTH : 34;
  localparam logic [QW-1:0] PMAX = {{(QW-POS_WIDTH+1){1'b0}}, {(POS_WIDTH-1){1'b1}}};
  localparam logic [QW-1:0] PMIN = ~PMAX;

  tjp_pkg::back_state_e state_q, state_d;

  logic [31:0]    start_q [JOINTS];
  logic [31:0]    end_q   [JOINTS];
  logic [NW-1:0]  num_q, den_q, rem_q;
  logic [31:0]    time_q;
  logic           last_q;
  logic [JW-1:0]  jidx_q;
  logic           neg_q;
  logic [31:0]    s_q;
  logic [MW-1:0]  mag_q;
  logic [XW-1:0]  x_q;
  logic [QB-1:0]  dvd_q, quo_q;
  logic [CW-1:0]  cnt_q;
  logic [31:0]    pos_q [NE];

  logic           out_valid_q;
  logic [31:0]    out_time_q;
  logic [31:0]    out_pos_q [NE];
  logic           out_last_q;

  // control decode
  logic pop, take_tick, last_joint, div_done, send;
  logic out_free;

  // datapath
  logic [32:0]       diff;
  logic [XW-1:0]     xr;
  logic [QB+NW-1:0]  xext;
  logic [NW:0]       r_n;
  logic [QB-1:0]     d_n, q_n;
  logic [QW-1:0]     sx, rr, qs;

  assign out_free   = !out_valid_q || rsp_o.ready;
  assign last_joint = (jidx_q == JW'(NE-1));
  assign div_done   = (cnt_q == CW'(ITER-1));

  always_comb begin
    state_d = state_q;
    case (state_q)
      tjp_pkg::BK_IDLE: begin
        if (job_valid_i && job_i.tick) state_d = tjp_pkg::BK_DIFF;
      end
      tjp_pkg::BK_DIFF: state_d = tjp_pkg::BK_MUL;
      tjp_pkg::BK_MUL:  state_d = tjp_pkg::BK_RND;
      tjp_pkg::BK_RND:  state_d = tjp_pkg::BK_DIV;
      tjp_pkg::BK_DIV: begin
        if (div_done) state_d = tjp_pkg::BK_FIX;
      end
      tjp_pkg::BK_FIX: state_d = last_joint ? tjp_pkg::BK_SEND : tjp_pkg::BK_DIFF;
      tjp_pkg::BK_SEND: begin
        if (out_free) state_d = tjp_pkg::BK_IDLE;
      end
      default: state_d = tjp_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    pop       = 1'b0;
    take_tick = 1'b0;
    send      = 1'b0;
    case (state_q)
      tjp_pkg::BK_IDLE: begin
        pop       = job_valid_i;
        take_tick = job_valid_i && job_i.tick;
      end
      tjp_pkg::BK_SEND: send = out_free;
      default: ;
    endcase
  end

  assign job_pop_o = pop;

  // four restoring division steps per cycle
  always_comb begin
    r_n = {1'b0, rem_q};
    d_n = dvd_q;
    q_n = quo_q;
    for (int k = 0; k < RADIX; k++) begin
      r_n = {r_n[NW-1:0], d_n[QB-1]};
      d_n = {d_n[QB-2:0], 1'b0};
      if (r_n >= {1'b0, den_q}) begin
        r_n = r_n - {1'b0, den_q};
        q_n = {q_n[QB-2:0], 1'b1};
      end else begin
        q_n = {q_n[QB-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    diff = {end_q[jidx_q][31], end_q[jidx_q]} - {start_q[jidx_q][31], start_q[jidx_q]};
    xr   = x_q + XW'(den_q >> 1);
    xext = (QB+NW)'(xr);
    sx   = {{(QW-32){s_q[31]}}, s_q};
    rr   = QW'(quo_q);
    qs   = neg_q ? (sx - rr) : (sx + rr);
    if ($signed(qs) > $signed(PMAX)) begin
      qs = PMAX;
    end else if ($signed(qs) < $signed(PMIN)) begin
      qs = PMIN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tjp_pkg::BK_IDLE;
      out_valid_q <= 1'b0;
      jidx_q      <= '0;
      cnt_q       <= '0;
    end else begin
      state_q <= state_d;
      if (send) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (take_tick) begin
        jidx_q <= '0;
      end else if ((state_q == tjp_pkg::BK_FIX) && !last_joint) begin
        jidx_q <= jidx_q + 1'b1;
      end
      if (state_q == tjp_pkg::BK_RND) begin
        cnt_q <= '0;
      end else if (state_q == tjp_pkg::BK_DIV) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && !job_i.tick) begin
      start_q[job_i.joint[JW-1:0]] <= job_i.start_angle;
      end_q[job_i.joint[JW-1:0]]   <= job_i.end_angle;
    end
    if (take_tick) begin
      num_q  <= job_i.num[NW-1:0];
      den_q  <= job_i.den[NW-1:0];
      time_q <= job_i.time_ticks;
      last_q <= job_i.last;
    end
    case (state_q)
      tjp_pkg::BK_DIFF: begin
        neg_q <= diff[32];
        s_q   <= start_q[jidx_q];
        mag_q <= diff[32] ? MW'(-diff) : diff[MW-1:0];
      end
      tjp_pkg::BK_MUL: x_q <= XW'(mag_q) * XW'(num_q);
      tjp_pkg::BK_RND: begin
        rem_q <= xext[QB+NW-1:QB];
        dvd_q <= xext[QB-1:0];
        quo_q <= '0;
      end
      tjp_pkg::BK_DIV: begin
        rem_q <= r_n[NW-1:0];
        dvd_q <= d_n;
        quo_q <= q_n;
      end
      tjp_pkg::BK_FIX: pos_q[jidx_q[JW-1:0]] <= qs[31:0];
      default: ;
    endcase
    if (send) begin
      out_time_q <= time_q;
      out_last_q <= last_q;
      for (int k = 0; k < NE; k++) begin
        out_pos_q[k] <= pos_q[k];
      end
    end
  end

  logic [31:0] pos_w [tjp_pkg::POS_OUTS];
  for (genvar g = 0; g < tjp_pkg::POS_OUTS; g++) begin : g_pos
    if (g < NE) begin : g_used
      assign pos_w[g] = out_pos_q[g];
    end else begin : g_zero
      assign pos_w[g] = '0;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.time_ticks  = out_time_q;
  assign rsp_o.segment_end = out_last_q;
  assign rsp_o.pos_j0      = pos_w[0];
  assign rsp_o.pos_j1      = pos_w[1];
  assign rsp_o.pos_j2      = pos_w[2];
  assign rsp_o.pos_j3      = pos_w[3];
  assign rsp_o.pos_j4      = pos_w[4];
  assign rsp_o.pos_j5      = pos_w[5];
endmodule

/* hdl/trapezoidal_joint_profile.sv */
// Top level: config registers, front part, job queue and back part.
// Load words are taken by the back part in its idle state. A tick word runs through the
// states DIFF, MUL, RND, DIV and FIX per emitted joint (up to six), then SEND; the
// shared 32 x 2*TICK_WIDTH multiplier and the 4-bit-per-cycle divider serve each joint
// in turn. A two-entry queue lets the front accept words while the back works, and the
// result register holds a finished word until it is taken. No clearing pass after reset.
module trapezoidal_joint_profile #(
  parameter int JOINTS     = 6,
  parameter int POS_WIDTH  = 32,
  parameter int TICK_WIDTH = 11
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tjp_req_if.sink     req_i,
  tjp_rsp_if.source   rsp_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int JOB_W = $bits(tjp_pkg::job_t);

  logic [tjp_pkg::ACCEL_W-1:0] accel_q;
  logic [TICK_WIDTH-1:0]       segment_q;
  logic                        wr_en;

  tjp_pkg::job_t front_job, back_job;
  logic [JOB_W-1:0] back_raw;
  logic push, full, pop, empty;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel_q   <= tjp_pkg::ACCEL_RESET;
      segment_q <= TICK_WIDTH'(tjp_pkg::SEGMENT_RESET);
    end else if (wr_en) begin
      case (paddr[2])
        tjp_pkg::REG_ACCEL:   accel_q   <= pwdata[tjp_pkg::ACCEL_W-1:0];
        tjp_pkg::REG_SEGMENT: segment_q <= pwdata[TICK_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      tjp_pkg::REG_ACCEL:   prdata = 32'(accel_q);
      tjp_pkg::REG_SEGMENT: prdata = 32'(segment_q);
      default:              prdata = '0;
    endcase
  end

  tjp_front #(
    .JOINTS     (JOINTS),
    .TICK_WIDTH (TICK_WIDTH)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_i),
    .accel_i   (accel_q),
    .segment_i (segment_q),
    .full_i    (full),
    .push_o    (push),
    .job_o     (front_job)
  );

  tjp_fifo #(
    .WIDTH (JOB_W),
    .DEPTH (2)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_job),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (back_raw),
    .empty_o (empty)
  );

  assign back_job = tjp_pkg::job_t'(back_raw);

  tjp_back #(
    .JOINTS     (JOINTS),
    .POS_WIDTH  (POS_WIDTH),
    .TICK_WIDTH (TICK_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (!empty),
    .job_i       (back_job),
    .job_pop_o   (pop),
    .rsp_o       (rsp_o)
  );
endmodule
